// ----- hw/rtl/mmpd_pkg.sv -----
// Shared types, register codes and constants for the motor mixer PWM duty block.
// Depends on nothing; used by mmpd_mix_pipe and motor_mixer_pwm_duty.
`timescale 1ns / 1ps

package mmpd_pkg;

    localparam int MOTORS_DEFAULT = 6;
    localparam int GAIN_REGS      = 6;
    localparam int MOTOR_W        = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int LEVEL_W        = 14;
    localparam int PULSE_W        = 16;
    localparam int DUTY_W         = 17;
    localparam int CMD_W          = 16;

    // Register indexes: gains live at 0 .. GAIN_REGS-1
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEVEL  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_ONE_MS = 3'd7;

    localparam logic [MOTOR_W-1:0] REMAP_MOTOR   = 3'd5;
    localparam logic [MOTOR_W-1:0] REMAP_CHANNEL = 3'd6;

    localparam logic [LEVEL_W-1:0] FULL_SCALE = 14'd10000;

    // floor(a / 100) = (a * RECIP_100) >> 31, exact for a <= 2^24
    localparam logic [24:0] RECIP_100       = 25'd21474837;
    localparam int          RECIP_100_SHIFT = 31;
    // floor(p / 10000) = (p * RECIP_10K) >> 44, exact for p < 2^30
    localparam logic [30:0] RECIP_10K       = 31'd1759218605;
    localparam int          RECIP_10K_SHIFT = 44;

    localparam logic [PULSE_W-1:0] DUTY_ONE_MS_RESET = 16'd24000;
    localparam logic [LEVEL_W-1:0] IDLE_LEVEL_RESET  = 14'd0;

    localparam logic [CFG_DATA_W-1:0] GAIN_RESET [GAIN_REGS] = '{
        32'd1679366425, 32'd1692919577, 32'd1679419367,
        32'd1692867047, 32'd1677721600, 32'd1677721600
    };

    typedef struct packed {
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] yaw;
        logic signed [CMD_W-1:0] thrust;
    } t_cmd;

    typedef struct packed {
        logic [MOTOR_W-1:0] channel;
        logic               last;
    } t_tag;

endpackage

// ----- hw/rtl/mmpd_mix_pipe.sv -----
// Eight-stage mixing datapath: weighted sum, divide by 100, clamp, duty scaling.
// Depends on mmpd_pkg.
`timescale 1ns / 1ps

module mmpd_mix_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_adv,
    input  logic                                i_vld,
    input  logic [mmpd_pkg::CFG_DATA_W-1:0]     i_gains,
    input  mmpd_pkg::t_cmd                      i_cmd,
    input  mmpd_pkg::t_tag                      i_tag,
    input  logic [mmpd_pkg::LEVEL_W-1:0]        i_idle_level,
    input  logic [mmpd_pkg::PULSE_W-1:0]        i_duty_one_ms,
    output logic                                o_vld,
    output logic [mmpd_pkg::DUTY_W-1:0]         o_duty,
    output mmpd_pkg::t_tag                      o_tag
);

    localparam int STAGES = 8;

    logic [STAGES-1:0]   r_vld;
    mmpd_pkg::t_tag      r_tag [STAGES];

    logic signed [23:0]  r_px, r_py, r_pz, r_pa;
    logic signed [25:0]  r_sum;
    logic [24:0]         r_abs;
    logic [49:0]         r_qm;
    logic [1:0]          r_neg;
    logic [mmpd_pkg::LEVEL_W-1:0] r_lvl;
    logic [29:0]         r_p;
    logic [60:0]         r_pm;
    logic [mmpd_pkg::DUTY_W-1:0]  r_duty;

    logic signed [7:0]   w_gx, w_gy, w_gz, w_ga;
    logic [18:0]         w_q;
    logic [mmpd_pkg::LEVEL_W-1:0] w_lo;
    logic [mmpd_pkg::LEVEL_W-1:0] n_lvl;

    assign w_gx = i_gains[7:0];
    assign w_gy = i_gains[15:8];
    assign w_gz = i_gains[23:16];
    assign w_ga = i_gains[31:24];

    assign w_q  = r_qm[mmpd_pkg::RECIP_100_SHIFT +: 19];
    assign w_lo = (i_idle_level > mmpd_pkg::FULL_SCALE) ? mmpd_pkg::FULL_SCALE : i_idle_level;

    always_comb begin
        if (r_neg[1] || (w_q < 19'(w_lo))) begin
            n_lvl = w_lo;
        end else if (w_q > 19'(mmpd_pkg::FULL_SCALE)) begin
            n_lvl = mmpd_pkg::FULL_SCALE;
        end else begin
            n_lvl = w_q[mmpd_pkg::LEVEL_W-1:0];
        end
    end

    // Valid bits: cleared by reset, shifted on each advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_tag[0] <= i_tag;
            for (int s = 1; s < STAGES; s++) begin
                r_tag[s] <= r_tag[s-1];
            end
            // stage 1: per-axis products
            r_px  <= w_gx * i_cmd.roll;
            r_py  <= w_gy * i_cmd.pitch;
            r_pz  <= w_gz * i_cmd.yaw;
            r_pa  <= w_ga * i_cmd.thrust;
            // stage 2: weighted sum
            r_sum <= {{2{r_px[23]}}, r_px} + {{2{r_py[23]}}, r_py}
                   + {{2{r_pz[23]}}, r_pz} + {{2{r_pa[23]}}, r_pa};
            // stage 3: magnitude, sign held aside for truncation toward zero
            r_abs    <= r_sum[25] ? 25'(-r_sum) : 25'(r_sum);
            r_neg[0] <= r_sum[25];
            // stage 4: reciprocal multiply for the divide by 100
            r_qm     <= r_abs * mmpd_pkg::RECIP_100;
            r_neg[1] <= r_neg[0];
            // stage 5: clamp; any negative quotient falls to the lower bound
            r_lvl    <= n_lvl;
            // stage 6: level times pulse count
            r_p   <= r_lvl * i_duty_one_ms;
            // stage 7: reciprocal multiply for the divide by full scale
            r_pm  <= r_p * mmpd_pkg::RECIP_10K;
            // stage 8: add the 1 ms base
            r_duty <= {1'b0, i_duty_one_ms}
                    + r_pm[mmpd_pkg::RECIP_10K_SHIFT +: mmpd_pkg::DUTY_W];
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_duty = r_duty;
    assign o_tag  = r_tag[STAGES-1];

endmodule

// ----- hw/rtl/motor_mixer_pwm_duty.sv -----
// Top level of the multirotor motor mixer with PWM duty output.
// Depends on mmpd_pkg and mmpd_mix_pipe.
`timescale 1ns / 1ps

// One input transaction carries roll, pitch, yaw and thrust commands and
// yields MOTORS output transactions, one per motor in index order, each with
// a channel number (motor 5 goes out on channel 6), a PWM duty count and a
// last flag on the final motor. The sequencer holds the command set and
// issues one motor per cycle, while the output does not stall, into an
// eight-stage datapath; the next item is taken in the cycle its
// predecessor's final motor issues, and items follow each other through the
// single shared datapath. A stall on the output freezes the whole datapath
// and stops the sequencer issuing; nothing is dropped or repeated.
// Configuration writes land at once and must be made only while the block is
// idle.

module motor_mixer_pwm_duty #(
    parameter int MOTORS = mmpd_pkg::MOTORS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [mmpd_pkg::CMD_W-1:0]   i_roll_cmd,
    input  logic signed [mmpd_pkg::CMD_W-1:0]   i_pitch_cmd,
    input  logic signed [mmpd_pkg::CMD_W-1:0]   i_yaw_cmd,
    input  logic signed [mmpd_pkg::CMD_W-1:0]   i_thrust_cmd,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mmpd_pkg::MOTOR_W-1:0]        o_channel,
    output logic [mmpd_pkg::DUTY_W-1:0]         o_duty,
    output logic                                o_last,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [mmpd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mmpd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [mmpd_pkg::MOTOR_W-1:0] LAST_MOTOR = mmpd_pkg::MOTOR_W'(MOTORS - 1);

    // configuration registers
    logic [mmpd_pkg::CFG_DATA_W-1:0] r_gains [mmpd_pkg::GAIN_REGS];
    logic [mmpd_pkg::LEVEL_W-1:0]    r_idle_level;
    logic [mmpd_pkg::PULSE_W-1:0]    r_duty_one_ms;

    // sequencer
    logic                            r_busy, n_busy;
    logic [mmpd_pkg::MOTOR_W-1:0]    r_motor, n_motor;
    mmpd_pkg::t_cmd                  r_cmd;

    logic                            w_adv;
    logic                            w_issue;
    logic                            w_final;
    logic                            w_take;
    mmpd_pkg::t_tag                  w_tag;
    mmpd_pkg::t_tag                  w_out_tag;
    logic                            w_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < mmpd_pkg::GAIN_REGS; g++) begin
                r_gains[g] <= mmpd_pkg::GAIN_RESET[g];
            end
            r_idle_level  <= mmpd_pkg::IDLE_LEVEL_RESET;
            r_duty_one_ms <= mmpd_pkg::DUTY_ONE_MS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mmpd_pkg::REG_IDLE_LEVEL: begin
                    r_idle_level <= i_cfg_data[mmpd_pkg::LEVEL_W-1:0];
                end
                mmpd_pkg::REG_DUTY_ONE_MS: begin
                    r_duty_one_ms <= i_cfg_data[mmpd_pkg::PULSE_W-1:0];
                end
                default: begin
                    // remaining indexes are the gain registers
                    r_gains[i_cfg_idx] <= i_cfg_data;
                end
            endcase
        end
    end

    // Advance the datapath whenever the output stage is empty or being drained
    assign w_adv   = !w_out_vld || i_ready;
    assign w_issue = r_busy && w_adv;
    assign w_final = (r_motor == LAST_MOTOR);
    assign o_ready = !r_busy || (w_adv && w_final);
    assign w_take  = i_valid && o_ready;

    always_comb begin
        n_busy  = r_busy;
        n_motor = r_motor;
        if (w_issue) begin
            if (w_final) begin
                n_busy  = 1'b0;
                n_motor = '0;
            end else begin
                n_motor = r_motor + 1'b1;
            end
        end
        if (w_take) begin
            n_busy  = 1'b1;
            n_motor = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_motor <= '0;
        end else begin
            r_busy  <= n_busy;
            r_motor <= n_motor;
        end
    end

    // Hold the command set for the whole motor sweep
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.roll   <= i_roll_cmd;
            r_cmd.pitch  <= i_pitch_cmd;
            r_cmd.yaw    <= i_yaw_cmd;
            r_cmd.thrust <= i_thrust_cmd;
        end
    end

    assign w_tag.channel = (r_motor == mmpd_pkg::REMAP_MOTOR) ? mmpd_pkg::REMAP_CHANNEL : r_motor;
    assign w_tag.last    = w_final;

    mmpd_mix_pipe u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_vld         (w_issue),
        .i_gains       (r_gains[r_motor]),
        .i_cmd         (r_cmd),
        .i_tag         (w_tag),
        .i_idle_level  (r_idle_level),
        .i_duty_one_ms (r_duty_one_ms),
        .o_vld         (w_out_vld),
        .o_duty        (o_duty),
        .o_tag         (w_out_tag)
    );

    assign o_valid   = w_out_vld;
    assign o_channel = w_out_tag.channel;
    assign o_last    = w_out_tag.last;

endmodule
